>>> rtl/core/blkpipe_pkg.sv
package blkpipe_pkg;

  // Ring buffer size in bytes and the largest transfer a single request may move.
  localparam int BUFFER_DEPTH = 256;
  localparam int MAX_TRANSFER = 64;

  // Byte address into the ring, and pointers with one extra wrap bit so that
  // a full ring and an empty ring can be told apart.
  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam int PTR_W  = ADDR_W + 1;

  // Field widths fixed by the stream format.
  localparam int ID_W    = 8;
  localparam int COUNT_W = 7;
  localparam int BYTE_W  = 8;

  // Depth of the command queue between the front and the back.
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  // Packed stream widths.
  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 24;
  localparam int M_TUSER_W = 2;

  // Request kinds.
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Result status codes.
  localparam logic ST_DONE    = 1'b0;
  localparam logic ST_BLOCKED = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic               first_beat;
    logic [ID_W-1:0]    requester;
    logic [COUNT_W-1:0] count;
    logic [BYTE_W-1:0]  write_byte;
  } cmd_t;

  typedef struct packed {
    logic               status;
    logic               byte_valid;
    logic [COUNT_W-1:0] transfer_count;
    logic               last;
    logic               read_would_block;
    logic               write_would_block;
  } meta_t;

endpackage

>>> rtl/core/blkpipe_front.sv
module blkpipe_front (
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Fields from bit 0: requester[7:0], count[14:8], write_byte[22:15], zero pad.
  input  logic [blkpipe_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // Fields from bit 0: req_type[0], first_beat[1].
  input  logic [blkpipe_pkg::S_TUSER_W-1:0]    s_axis_tuser,
  input  logic                                 q_full_i,
  output logic                                 push_o,
  output blkpipe_pkg::cmd_t                    cmd_o
);

  logic [blkpipe_pkg::COUNT_W-1:0] raw_count;

  assign raw_count     = s_axis_tdata[14:8];
  assign s_axis_tready = !q_full_i;
  assign push_o        = s_axis_tvalid && !q_full_i;

  // Counts above the largest transfer are taken as the largest transfer.
  always_comb begin
    cmd_o.req_type   = s_axis_tuser[0];
    cmd_o.first_beat = s_axis_tuser[1];
    cmd_o.requester  = s_axis_tdata[7:0];
    cmd_o.write_byte = s_axis_tdata[22:15];
    if (raw_count > blkpipe_pkg::COUNT_W'(blkpipe_pkg::MAX_TRANSFER)) begin
      cmd_o.count = blkpipe_pkg::COUNT_W'(blkpipe_pkg::MAX_TRANSFER);
    end else begin
      cmd_o.count = raw_count;
    end
  end

endmodule

>>> rtl/core/blkpipe_cmdq.sv
module blkpipe_cmdq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  blkpipe_pkg::cmd_t push_cmd_i,
  output logic              full_o,
  output logic              valid_o,
  output blkpipe_pkg::cmd_t head_o,
  input  logic              pop_i
);

  blkpipe_pkg::cmd_t                entry_q [blkpipe_pkg::CMDQ_DEPTH];
  logic [blkpipe_pkg::CMDQ_AW-1:0]  wr_idx_q, wr_idx_d;
  logic [blkpipe_pkg::CMDQ_AW-1:0]  rd_idx_q, rd_idx_d;
  logic [blkpipe_pkg::CMDQ_AW:0]    used_q, used_d;
  logic                             do_push, do_pop;

  assign full_o  = (used_q == (blkpipe_pkg::CMDQ_AW+1)'(blkpipe_pkg::CMDQ_DEPTH));
  assign valid_o = (used_q != '0);
  assign head_o  = entry_q[rd_idx_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_idx_d = do_push ? wr_idx_q + 1'b1 : wr_idx_q;
    rd_idx_d = do_pop  ? rd_idx_q + 1'b1 : rd_idx_q;
    used_d   = used_q;
    if (do_push && !do_pop) begin
      used_d = used_q + 1'b1;
    end else if (do_pop && !do_push) begin
      used_d = used_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      used_q   <= '0;
    end else begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      used_q   <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_idx_q] <= push_cmd_i;
    end
  end

endmodule

>>> rtl/core/blkpipe_back.sv
module blkpipe_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cmd_valid_i,
  input  blkpipe_pkg::cmd_t                    cmd_i,
  output logic                                 cmd_pop_o,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // Fields from bit 0: read_byte[7:0], transfer_count[14:8],
  // read_would_block[15], write_would_block[16], zero pad.
  output logic [blkpipe_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // Fields from bit 0: status[0], byte_valid[1].
  output logic [blkpipe_pkg::M_TUSER_W-1:0]    m_axis_tuser,
  output logic                                 m_axis_tlast
);

  localparam int PW = blkpipe_pkg::PTR_W;
  localparam int AW = blkpipe_pkg::ADDR_W;
  localparam int CW = blkpipe_pkg::COUNT_W;
  localparam int IW = blkpipe_pkg::ID_W;
  localparam int BW = blkpipe_pkg::BYTE_W;
  localparam logic [PW:0] DepthCmp = (PW+1)'(blkpipe_pkg::BUFFER_DEPTH);

  // Ring storage; entries are only read once they have been written.
  logic [BW-1:0] mem [blkpipe_pkg::BUFFER_DEPTH];

  // Architectural pipe state.
  logic [PW-1:0] rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic          rwait_q, rwait_d, wwait_q, wwait_d;
  logic [IW-1:0] rid_q, rid_d, wid_q, wid_d;
  logic [CW-1:0] wcnt_q, wcnt_d, beats_left_q, beats_left_d, wtotal_q, wtotal_d;

  // Read emission: bytes still to send after the current one.
  logic [CW-1:0] em_left_q, em_left_d, em_n_q, em_n_d;
  logic [AW-1:0] em_addr_q, em_addr_d;
  logic [IW-1:0] em_who_q, em_who_d;

  // Pending stage (alongside the memory read) and output register.
  logic                p_valid_q, p_valid_d;
  blkpipe_pkg::meta_t  p_meta_q, gen_meta;
  logic [BW-1:0]       rd_data_q;
  logic                o_valid_q;
  blkpipe_pkg::meta_t  o_meta_q;
  logic [BW-1:0]       o_byte_q;

  logic          out_load, p_free, emitting, gen, issue, mem_we;
  logic [AW-1:0] issue_addr;
  logic [IW-1:0] who;
  logic [PW-1:0] fill_q, fill_d;
  logic [CW-1:0] n_rd, left_cur, left_new, total_cur;
  logic          admit, push;

  assign out_load  = p_valid_q && (!o_valid_q || m_axis_tready);
  assign p_free    = !p_valid_q || out_load;
  assign emitting  = (em_left_q != '0);
  assign cmd_pop_o = cmd_valid_i && !emitting && p_free;
  assign fill_q    = wr_ptr_q - rd_ptr_q;
  assign fill_d    = wr_ptr_d - rd_ptr_d;

  always_comb begin
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    rwait_d      = rwait_q;
    rid_d        = rid_q;
    wwait_d      = wwait_q;
    wid_d        = wid_q;
    wcnt_d       = wcnt_q;
    beats_left_d = beats_left_q;
    wtotal_d     = wtotal_q;
    em_left_d    = em_left_q;
    em_n_d       = em_n_q;
    em_addr_d    = em_addr_q;
    em_who_d     = em_who_q;
    gen          = 1'b0;
    issue        = 1'b0;
    issue_addr   = em_addr_q;
    mem_we       = 1'b0;
    who          = em_who_q;
    admit        = 1'b0;
    push         = 1'b0;
    left_cur     = beats_left_q;
    total_cur    = wtotal_q;
    left_new     = '0;
    n_rd         = '0;
    gen_meta     = '0;
    gen_meta.last = 1'b1;

    if (emitting && p_free) begin
      gen                     = 1'b1;
      issue                   = 1'b1;
      gen_meta.byte_valid     = 1'b1;
      gen_meta.transfer_count = em_n_q;
      gen_meta.last           = (em_left_q == CW'(1));
      em_left_d               = em_left_q - 1'b1;
      em_addr_d               = em_addr_q + 1'b1;
    end else if (cmd_pop_o) begin
      who = cmd_i.requester;
      if (cmd_i.req_type == blkpipe_pkg::REQ_READ) begin
        gen = 1'b1;
        if (cmd_i.count == '0) begin
          gen_meta.status = blkpipe_pkg::ST_DONE;
        end else if (rwait_q && (rid_q != who || fill_q == '0)) begin
          gen_meta.status = blkpipe_pkg::ST_BLOCKED;
        end else if (!rwait_q && fill_q == '0) begin
          rwait_d         = 1'b1;
          rid_d           = who;
          gen_meta.status = blkpipe_pkg::ST_BLOCKED;
        end else begin
          if (rwait_q) begin
            rwait_d = 1'b0;
            rid_d   = '0;
          end
          if (PW'(cmd_i.count) < fill_q) begin
            n_rd = cmd_i.count;
          end else begin
            n_rd = fill_q[CW-1:0];
          end
          rd_ptr_d                = rd_ptr_q + PW'(n_rd);
          issue                   = 1'b1;
          issue_addr              = rd_ptr_q[AW-1:0];
          gen_meta.byte_valid     = 1'b1;
          gen_meta.transfer_count = n_rd;
          gen_meta.last           = (n_rd == CW'(1));
          em_left_d               = n_rd - 1'b1;
          em_addr_d               = rd_ptr_q[AW-1:0] + 1'b1;
          em_n_d                  = n_rd;
          em_who_d                = who;
        end
      end else if (cmd_i.first_beat) begin
        beats_left_d = '0;
        wtotal_d     = '0;
        if (cmd_i.count == '0) begin
          gen             = 1'b1;
          gen_meta.status = blkpipe_pkg::ST_DONE;
        end else if (wwait_q) begin
          if (wid_q != who || ((PW+1)'(fill_q) + (PW+1)'(cmd_i.count)) > DepthCmp) begin
            gen             = 1'b1;
            gen_meta.status = blkpipe_pkg::ST_BLOCKED;
          end else begin
            wwait_d = 1'b0;
            wid_d   = '0;
            wcnt_d  = '0;
            admit   = 1'b1;
          end
        end else if (((PW+1)'(fill_q) + (PW+1)'(cmd_i.count)) > DepthCmp) begin
          wwait_d         = 1'b1;
          wid_d           = who;
          wcnt_d          = cmd_i.count;
          gen             = 1'b1;
          gen_meta.status = blkpipe_pkg::ST_BLOCKED;
        end else begin
          admit = 1'b1;
        end
        if (admit) begin
          push      = 1'b1;
          left_cur  = cmd_i.count;
          total_cur = cmd_i.count;
          wtotal_d  = cmd_i.count;
        end
      end else if (beats_left_q != '0) begin
        push = 1'b1;
      end
      // A beat with no open write is dropped without a result.

      if (push) begin
        mem_we                  = 1'b1;
        wr_ptr_d                = wr_ptr_q + 1'b1;
        left_new                = left_cur - 1'b1;
        beats_left_d            = left_new;
        gen                     = 1'b1;
        gen_meta.status         = blkpipe_pkg::ST_DONE;
        gen_meta.last           = (left_new == '0);
        gen_meta.transfer_count = (left_new == '0) ? total_cur : '0;
      end
    end

    // Would-block answers reflect the state once this step is complete.
    gen_meta.read_would_block  = (fill_d == '0) || (rwait_d && rid_d != who);
    gen_meta.write_would_block = (((PW+1)'(fill_d) + (PW+1)'(wcnt_d)) > DepthCmp) ||
                                 (wwait_d && wid_d != who);

    p_valid_d = gen ? 1'b1 : (out_load ? 1'b0 : p_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q     <= '0;
      wr_ptr_q     <= '0;
      rwait_q      <= 1'b0;
      rid_q        <= '0;
      wwait_q      <= 1'b0;
      wid_q        <= '0;
      wcnt_q       <= '0;
      beats_left_q <= '0;
      wtotal_q     <= '0;
      em_left_q    <= '0;
      p_valid_q    <= 1'b0;
      o_valid_q    <= 1'b0;
    end else begin
      rd_ptr_q     <= rd_ptr_d;
      wr_ptr_q     <= wr_ptr_d;
      rwait_q      <= rwait_d;
      rid_q        <= rid_d;
      wwait_q      <= wwait_d;
      wid_q        <= wid_d;
      wcnt_q       <= wcnt_d;
      beats_left_q <= beats_left_d;
      wtotal_q     <= wtotal_d;
      em_left_q    <= em_left_d;
      p_valid_q    <= p_valid_d;
      if (out_load) begin
        o_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    em_n_q    <= em_n_d;
    em_addr_q <= em_addr_d;
    em_who_q  <= em_who_d;
    if (gen) begin
      p_meta_q <= gen_meta;
    end
    if (out_load) begin
      o_meta_q <= p_meta_q;
      o_byte_q <= p_meta_q.byte_valid ? rd_data_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_ptr_q[AW-1:0]] <= cmd_i.write_byte;
    end
    if (issue) begin
      rd_data_q <= mem[issue_addr];
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tlast  = o_meta_q.last;
  assign m_axis_tuser  = {o_meta_q.byte_valid, o_meta_q.status};
  assign m_axis_tdata  = {7'b0, o_meta_q.write_would_block, o_meta_q.read_would_block,
                          o_meta_q.transfer_count, o_byte_q};

  // The ring never holds more bytes than it has room for.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (PW+1)'(fill_q) <= DepthCmp)
    else $error("ring fill exceeds its depth");

  // A result waiting in the pending stage is neither lost nor overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q && !out_load |=> p_valid_q && $stable(p_meta_q))
    else $error("pending result overwritten while stalled");

  // A byte-carrying result always belongs to a completed, non-empty read.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q && p_meta_q.byte_valid |->
      p_meta_q.status == blkpipe_pkg::ST_DONE && p_meta_q.transfer_count != '0)
    else $error("read byte with bad status or count");

  // A held writer slot always records a non-zero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wwait_q |-> wcnt_q != '0)
    else $error("waiting writer without a count");

endmodule

>>> rtl/core/blocking_pipe_fifo_unit.sv
// Blocking byte pipe on a ring of blkpipe_pkg::BUFFER_DEPTH bytes, with one
// waiting-reader slot and one waiting-writer slot. Requests arrive as stream
// transfers on the slave side; a front stage clamps the count and classifies
// the request, a four-entry command queue decouples it from the back stage,
// and the back stage owns the ring, the pointers and the slots and produces
// one result transfer per byte read, per write beat, or per blocked or
// zero-count request. A read sends its bytes one byte a cycle through the
// ring's single registered read port while the output is not stalled. A
// stray write beat is consumed with no result. A request passes through the
// command queue, and its result through the back stage's pending stage and
// output register, before the result is offered on the master side. The
// input stays ready while the command queue has room, so requests keep
// flowing while a result waits to be taken. The ring is not cleared at
// reset; only bytes that were written are ever read back. Every result also
// carries the read and write would-block answers for its requester, taken
// once the request has been carried out.
module blocking_pipe_fifo_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Fields from bit 0: requester[7:0], count[14:8], write_byte[22:15], zero pad.
  input  logic [blkpipe_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // Fields from bit 0: req_type[0], first_beat[1].
  input  logic [blkpipe_pkg::S_TUSER_W-1:0]    s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // Fields from bit 0: read_byte[7:0], transfer_count[14:8],
  // read_would_block[15], write_would_block[16], zero pad.
  output logic [blkpipe_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // Fields from bit 0: status[0], byte_valid[1].
  output logic [blkpipe_pkg::M_TUSER_W-1:0]    m_axis_tuser,
  output logic                                 m_axis_tlast
);

  // Decoded request from the front stage into the command queue.
  logic              push;
  blkpipe_pkg::cmd_t push_cmd;
  logic              q_full;

  // Head of the command queue towards the back stage.
  logic              head_valid;
  blkpipe_pkg::cmd_t head_cmd;
  logic              head_pop;

  blkpipe_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  blkpipe_cmdq u_cmdq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .valid_o    (head_valid),
    .head_o     (head_cmd),
    .pop_i      (head_pop)
  );

  // The back stage executes one queued command at a time against the ring
  // and drives the result stream through its own output register.
  blkpipe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (head_valid),
    .cmd_i         (head_cmd),
    .cmd_pop_o     (head_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

>>> dv/blocking_pipe_fifo_unit_tb.sv
// Self-checking testbench for the blocking byte pipe. Requests are sent as
// stream transfers on the slave side, and an in-bench predictor of the ring,
// the pointers and the two waiting slots works out every result transfer the
// block owes. Each result taken on the master side is compared, field by
// field, with the oldest result still owed.
module blocking_pipe_fifo_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import blkpipe_pkg::*;

  // Cycles to let pass once nothing is owed: a stray beat may still be passing
  // through the command queue.
  localparam int SETTLE_CYCLES = 16;
  // Upper bound, in cycles, on one wait for the owed results to drain.
  localparam int DRAIN_LIMIT   = 40000;
  // Number of counted requests in the random phase.
  localparam int RANDOM_ITEMS  = 120;

  // One result transfer as the block should produce it.
  typedef struct {
    logic               status;
    logic [BYTE_W-1:0]  rbyte;
    logic               has_byte;
    logic [COUNT_W-1:0] tcount;
    logic               last;
    logic               rd_block;
    logic               wr_block;
  } pipe_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [S_TUSER_W-1:0] s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;
  logic                 m_axis_tlast;

  // Predicted state of the pipe. The pointers carry one wrap bit, exactly as
  // in the block, so that a full ring and an empty ring differ.
  logic [BYTE_W-1:0]  ring_mem [BUFFER_DEPTH];
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W-1:0]   wr_ptr;
  logic               rd_park;
  logic [ID_W-1:0]    rd_park_id;
  logic               wr_park;
  logic [ID_W-1:0]    wr_park_id;
  int                 wr_park_count;
  int                 beats_owed;
  int                 beats_total;

  // Results owed by the block, oldest first.
  pipe_result_t owed_results [$];

  int errors;
  int live_items;     // accepted requests that caused at least one result
  int rx_hold_left;   // cycles for which the receiver still holds off
  bit calm;           // suppresses random idling on both sides

  blocking_pipe_fifo_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------

  // Bytes held in the ring; the pointer difference wraps at the pointer width.
  function automatic int ring_fill();
    logic [PTR_W-1:0] diff;
    diff = wr_ptr - rd_ptr;
    return int'(diff);
  endfunction

  // Records one owed result. The would-block answers are taken on the state
  // as it stands once the request has been carried out.
  function automatic void owe_result(logic [ID_W-1:0] who, logic status,
                                     logic [BYTE_W-1:0] rbyte, logic has_byte,
                                     logic [COUNT_W-1:0] tcount, logic last);
    pipe_result_t r;
    int fill;
    fill       = ring_fill();
    r.status   = status;
    r.rbyte    = rbyte;
    r.has_byte = has_byte;
    r.tcount   = tcount;
    r.last     = last;
    r.rd_block = (fill == 0) || (rd_park && rd_park_id != who);
    r.wr_block = (fill + wr_park_count > BUFFER_DEPTH) || (wr_park && wr_park_id != who);
    owed_results.push_back(r);
  endfunction

  // Applies one accepted request to the predicted state and returns how many
  // results it causes; a stray write beat causes none.
  function automatic int predict_request(logic kind, logic [ID_W-1:0] who,
                                         logic [COUNT_W-1:0] cnt_field, logic first,
                                         logic [BYTE_W-1:0] wbyte);
    int cnt;
    int fill;
    int n;
    logic [BYTE_W-1:0] taken [MAX_TRANSFER];
    cnt  = (cnt_field > MAX_TRANSFER) ? MAX_TRANSFER : int'(cnt_field);
    fill = ring_fill();
    if (kind == REQ_READ) begin
      if (cnt == 0) begin
        owe_result(who, ST_DONE, '0, 1'b0, '0, 1'b1);
        return 1;
      end
      if (rd_park) begin
        // Only the parked reader gets through, and only once data is there.
        if (rd_park_id != who || fill == 0) begin
          owe_result(who, ST_BLOCKED, '0, 1'b0, '0, 1'b1);
          return 1;
        end
        rd_park    = 1'b0;
        rd_park_id = '0;
      end else if (fill == 0) begin
        rd_park    = 1'b1;
        rd_park_id = who;
        owe_result(who, ST_BLOCKED, '0, 1'b0, '0, 1'b1);
        return 1;
      end
      n = (fill < cnt) ? fill : cnt;
      for (int i = 0; i < n; i++) begin
        taken[i] = ring_mem[(int'(rd_ptr) + i) % BUFFER_DEPTH];
      end
      rd_ptr = rd_ptr + n[PTR_W-1:0];
      for (int i = 0; i < n; i++) begin
        owe_result(who, ST_DONE, taken[i], 1'b1, n[COUNT_W-1:0], i == n - 1);
      end
      return n;
    end
    if (first) begin
      // A new first beat drops whatever the open write still owed.
      beats_owed  = 0;
      beats_total = 0;
      if (cnt == 0) begin
        owe_result(who, ST_DONE, '0, 1'b0, '0, 1'b1);
        return 1;
      end
      if (wr_park) begin
        if (wr_park_id != who || fill + cnt > BUFFER_DEPTH) begin
          owe_result(who, ST_BLOCKED, '0, 1'b0, '0, 1'b1);
          return 1;
        end
        wr_park       = 1'b0;
        wr_park_id    = '0;
        wr_park_count = 0;
      end else if (fill + cnt > BUFFER_DEPTH) begin
        wr_park       = 1'b1;
        wr_park_id    = who;
        wr_park_count = cnt;
        owe_result(who, ST_BLOCKED, '0, 1'b0, '0, 1'b1);
        return 1;
      end
      beats_total = cnt;
      beats_owed  = cnt;
    end else if (beats_owed == 0) begin
      return 0;
    end
    ring_mem[int'(wr_ptr) % BUFFER_DEPTH] = wbyte;
    wr_ptr     = wr_ptr + 1'b1;
    beats_owed = beats_owed - 1;
    owe_result(who, ST_DONE, '0, 1'b0,
               (beats_owed == 0) ? beats_total[COUNT_W-1:0] : '0, beats_owed == 0);
    return 1;
  endfunction

  // ------------------------------------------------------------------------
  // Request side
  // ------------------------------------------------------------------------

  // Offers one request and returns once its transfer has been accepted. Inputs
  // change only at the falling edge; acceptance is judged at the rising edge.
  task automatic send_request(logic kind, logic [ID_W-1:0] who, logic [COUNT_W-1:0] cnt,
                              logic first, logic [BYTE_W-1:0] wbyte);
    while (!calm && $urandom_range(99) < 13) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {1'b0, wbyte, cnt, who};
    s_axis_tuser  = {first, kind};
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_request(kind, who, cnt, first, wbyte) > 0) begin
      live_items++;
    end
  endtask

  // Sends a write: the first beat, then further beats for as long as the
  // predictor says the write is open, stopping early after cut beats so that
  // broken writes can be made. Later beats now and then carry another id.
  task automatic send_write(logic [ID_W-1:0] who, int cnt, int cut);
    int sent;
    logic [ID_W-1:0] beat_id;
    send_request(REQ_WRITE, who, cnt[COUNT_W-1:0], 1'b1, BYTE_W'($urandom_range(255)));
    sent = 1;
    while (beats_owed != 0 && sent < cut) begin
      beat_id = ($urandom_range(9) == 0) ? ID_W'($urandom_range(255)) : who;
      send_request(REQ_WRITE, beat_id, COUNT_W'($urandom_range(127)), 1'b0,
                   BYTE_W'($urandom_range(255)));
      sent++;
    end
  endtask

  // Picks the parked reader when there is one, so that reads can get through.
  function automatic logic [ID_W-1:0] reader_for(logic [ID_W-1:0] fallback);
    return rd_park ? rd_park_id : fallback;
  endfunction

  // Drops the request valid and waits until every owed result has come back.
  task automatic wait_drained();
    int guard;
    guard = 0;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (owed_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ------------------------------------------------------------------------
  // Result side
  // ------------------------------------------------------------------------

  // Receiver readiness: a long hold-off when one is asked for, otherwise
  // random stalls with a chance of about 13 in a hundred.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_axis_tready = 1'b0;
      end else if (!calm && $urandom_range(99) < 13) begin
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  task automatic check_field(string what, int want, int seen);
    if (want != seen) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, seen);
    end
  endtask

  // Every accepted result transfer is matched against the oldest owed result.
  always @(posedge clk_i) begin
    pipe_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: result with none owed, expected nothing, got tdata %h tuser %b",
                 $time, m_axis_tdata, m_axis_tuser);
      end else begin
        want = owed_results.pop_front();
        check_field("status", want.status, m_axis_tuser[0]);
        check_field("byte_valid", want.has_byte, m_axis_tuser[1]);
        check_field("read_byte", want.rbyte, m_axis_tdata[7:0]);
        check_field("transfer_count", want.tcount, m_axis_tdata[14:8]);
        check_field("read_would_block", want.rd_block, m_axis_tdata[15]);
        check_field("write_would_block", want.wr_block, m_axis_tdata[16]);
        check_field("last", want.last, m_axis_tlast);
      end
    end
  end

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // A read on the empty ring parks its requester; another reader is kept out
  // and a zero-count read only queries. The parked reader then takes the
  // bytes with an oversized count, which returns fewer bytes than asked.
  task automatic test_reader_slot();
    send_request(REQ_READ, 8'h00, 7'd5, 1'b0, 8'h00);
    send_request(REQ_READ, 8'hFF, 7'd64, 1'b0, 8'hFF);
    send_request(REQ_READ, 8'h07, 7'd0, 1'b0, 8'h00);
    send_request(REQ_WRITE, 8'hFF, 7'd3, 1'b1, 8'h00);
    send_request(REQ_WRITE, 8'hFF, 7'd3, 1'b0, 8'hFF);
    send_request(REQ_WRITE, 8'hFF, 7'd3, 1'b0, 8'h5A);
    send_request(REQ_READ, 8'hFF, 7'd2, 1'b0, 8'h00);
    send_request(REQ_READ, 8'h00, 7'd127, 1'b0, 8'h00);
  endtask

  // A zero-count write, a stray beat that the block swallows, and a fresh
  // read on the empty ring that parks again.
  task automatic test_zero_and_stray();
    send_request(REQ_WRITE, 8'h09, 7'd0, 1'b1, 8'hFF);
    send_request(REQ_WRITE, 8'h09, 7'd5, 1'b0, 8'hFF);
    send_request(REQ_READ, 8'h01, 7'd1, 1'b0, 8'h00);
  endtask

  // A new first beat in the middle of a write drops the beats still owed; an
  // oversized write count is clamped before it is cut short the same way.
  task automatic test_write_restart();
    send_request(REQ_WRITE, 8'h03, 7'd4, 1'b1, 8'h80);
    send_request(REQ_WRITE, 8'h03, 7'd4, 1'b0, 8'h01);
    send_request(REQ_WRITE, 8'h03, 7'd2, 1'b1, 8'h7F);
    send_request(REQ_WRITE, 8'h03, 7'd2, 1'b0, 8'hFE);
    send_request(REQ_WRITE, 8'h03, 7'd2, 1'b0, 8'h33);
    send_request(REQ_READ, 8'h01, 7'd64, 1'b0, 8'h00);
    send_request(REQ_WRITE, 8'hC8, 7'd127, 1'b1, 8'hAA);
    send_request(REQ_WRITE, 8'hC8, 7'd1, 1'b1, 8'h55);
    send_request(REQ_READ, 8'hC8, 7'd2, 1'b0, 8'h00);
  endtask

  // Fills the ring to the brim, then parks a writer that does not fit, shows
  // a second writer kept out, frees space with a read and lets the parked
  // writer through. The ring is emptied again at the end.
  task automatic test_full_ring();
    while (ring_fill() != 0) begin
      send_request(REQ_READ, reader_for(8'h44), 7'd64, 1'b0, 8'h00);
    end
    while (ring_fill() + MAX_TRANSFER <= BUFFER_DEPTH && !wr_park) begin
      send_write(8'h11, MAX_TRANSFER, MAX_TRANSFER + 1);
    end
    send_write(8'h5A, 10, 128);
    send_write(8'h33, 1, 128);
    send_request(REQ_READ, reader_for(8'h44), 7'd20, 1'b0, 8'h00);
    send_write(8'h33, 1, 128);
    send_write(8'h5A, 10, 128);
    while (ring_fill() != 0) begin
      send_request(REQ_READ, reader_for(8'hC3), 7'd64, 1'b0, 8'h00);
    end
  endtask

  // The receiver holds off for a long stretch while writes and reads keep
  // coming, so the command queue fills and the input is stalled.
  task automatic test_backpressure();
    rx_hold_left = 400;
    repeat (4) begin
      send_write(8'h21, 8, 128);
      send_request(REQ_READ, reader_for(8'h21), 7'd8, 1'b0, 8'h00);
    end
  endtask

  // Mostly requesters from a small pool, so that parked readers and writers
  // come back; now and then any id at all.
  function automatic logic [ID_W-1:0] pick_requester(logic parked, logic [ID_W-1:0] parked_id);
    if (parked && $urandom_range(1) == 1) begin
      return parked_id;
    end
    case ($urandom_range(4))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h5A;
      3: return 8'hA5;
      default: return ID_W'($urandom_range(255));
    endcase
  endfunction

  // Mostly small counts, with zero, the largest and oversized ones mixed in.
  function automatic int pick_count(int typical_max);
    int r;
    r = $urandom_range(99);
    if (r < 4) begin
      return 0;
    end else if (r < 10) begin
      return $urandom_range(127, MAX_TRANSFER + 1);
    end else if (r < 18) begin
      return MAX_TRANSFER;
    end
    return $urandom_range(typical_max, 1);
  endfunction

  // Random mix of reads, well-formed writes, broken writes and stray beats,
  // with a stretch in the middle where neither side idles.
  task automatic test_random_traffic();
    int start_items;
    int done;
    int r;
    int cnt;
    logic [ID_W-1:0] who;
    start_items = live_items;
    done        = 0;
    while (done < RANDOM_ITEMS) begin
      calm = (done >= 40 && done < 80);
      r    = $urandom_range(99);
      if (r < 5) begin
        send_request(REQ_WRITE, ID_W'($urandom_range(255)), COUNT_W'($urandom_range(127)),
                     1'b0, BYTE_W'($urandom_range(255)));
      end else if (r < 50) begin
        who = pick_requester(rd_park, rd_park_id);
        send_request(REQ_READ, who, COUNT_W'(pick_count(16)), 1'b0,
                     BYTE_W'($urandom_range(255)));
      end else begin
        who = pick_requester(wr_park, wr_park_id);
        cnt = pick_count(32);
        send_write(who, cnt, ($urandom_range(99) < 5) ? $urandom_range(cnt) : 128);
      end
      done = live_items - start_items;
    end
    calm = 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    rd_ptr        = '0;
    wr_ptr        = '0;
    rd_park       = 1'b0;
    rd_park_id    = '0;
    wr_park       = 1'b0;
    wr_park_id    = '0;
    wr_park_count = 0;
    beats_owed    = 0;
    beats_total   = 0;
    errors        = 0;
    live_items    = 0;
    rx_hold_left  = 0;
    calm          = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reader_slot();
    test_zero_and_stray();
    test_write_restart();
    // The sender pauses here until every owed result has come back.
    wait_drained();
    test_full_ring();
    wait_drained();
    test_backpressure();
    wait_drained();
    test_random_traffic();
    wait_drained();

    if (owed_results.size() != 0) begin
      errors++;
      $display("%0t: %0d owed results never arrived", $time, owed_results.size());
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
